// ===== rtl/core/spce_pkg.sv =====
// Package for the serial programmer command engine.
// Request and result payload types, result kinds, parse phases, register indexes.
// No dependencies.
package spce_pkg;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  host_byte;
        logic [15:0] read_data;
    } spce_in_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] reply_or_data;
        logic [16:0] mem_address;
        logic        command_done;
    } spce_out_t;

    localparam logic [3:0] K_REPLY     = 4'd0;
    localparam logic [3:0] K_ERASE     = 4'd1;
    localparam logic [3:0] K_FILL      = 4'd2;
    localparam logic [3:0] K_PAGE_WR   = 4'd3;
    localparam logic [3:0] K_FLASH_RD  = 4'd4;
    localparam logic [3:0] K_WORD_RD   = 4'd5;
    localparam logic [3:0] K_EE_RD     = 4'd6;
    localparam logic [3:0] K_EE_WR     = 4'd7;
    localparam logic [3:0] K_LOCK_WR   = 4'd8;
    localparam logic [3:0] K_FUSE_RD   = 4'd9;
    localparam logic [3:0] K_ERASE_APP = 4'd10;
    localparam logic [3:0] K_EXIT      = 4'd11;

    localparam logic [2:0] REG_IDENT   = 3'd0;
    localparam logic [2:0] REG_VMAJOR  = 3'd1;
    localparam logic [2:0] REG_VMINOR  = 3'd2;
    localparam logic [2:0] REG_SIG     = 3'd3;
    localparam logic [2:0] REG_PAGE    = 3'd4;

    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_Q   = 8'h3F;
    localparam logic [7:0] CH_Y   = 8'h59;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_T44 = 8'h44;

    // room for up to eight results per request, handed to the emitter as a batch
    typedef struct packed {
        logic [3:0]       count;
        spce_out_t [7:0]  res;
    } spce_batch_t;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_ARG1     = 8'b0000_0010,
        PH_ARG2     = 8'b0000_0100,
        PH_SIZE_LO  = 8'b0000_1000,
        PH_TYPE     = 8'b0001_0000,
        PH_WRITE    = 8'b0010_0000,
        PH_BLK_WAIT = 8'b0100_0000,
        PH_WAIT     = 8'b1000_0000
    } spce_phase_t;

endpackage

// ===== rtl/core/spce_parser.sv =====
// Front part: parses one request per cycle while the queue has room, and builds its result batch.
// Depends on spce_pkg.
module spce_parser
    import spce_pkg::*;
#(
    parameter int ADDR_BITS = 17
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  spce_in_t        in_data,
    output logic            b_valid,
    input  logic            b_ready,
    output spce_batch_t     b_data,
    input  logic [55:0]     ident,
    input  logic [3:0]      vmajor,
    input  logic [3:0]      vminor,
    input  logic [23:0]     signature,
    input  logic [15:0]     page_bytes
);
    localparam int AW = ADDR_BITS;

    spce_phase_t    phase_reg, phase_next;
    logic [7:0]     cmd_reg, cmd_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [15:0]    rem_reg, rem_next;
    logic           ee_reg, ee_next;
    logic           odd_reg, odd_next;
    logic [7:0]     held_reg, held_next;
    logic [AW-1:0]  page_reg, page_next;
    spce_batch_t    bat;
    logic           fire;

    assign in_ready = b_ready;
    assign fire     = in_valid && in_ready;
    assign b_valid  = fire && (bat.count != 4'd0);
    assign b_data   = bat;

    function automatic logic [16:0] a17(input logic [AW-1:0] a);
        logic [31:0] w;
        begin
            w = 32'(a);
            return w[16:0];
        end
    endfunction

    always_comb begin
        logic [7:0]    b;
        logic [15:0]   d;
        logic [15:0]   r1;
        logic [AW-1:0] adv;
        logic [AW-1:0] sa;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        ee_next    = ee_reg;
        odd_next   = odd_reg;
        held_next  = held_reg;
        page_next  = page_reg;
        bat        = '0;
        b   = in_data.host_byte;
        d   = in_data.read_data;
        adv = addr_reg + AW'(2);
        r1  = rem_reg - 16'd1;
        sa  = AW'(({24'd0, held_reg} << 9) | ({24'd0, b} << 1));
        if (in_data.opcode) begin
            if (phase_reg == PH_BLK_WAIT) begin
                rem_next = r1;
                bat.res[0] = '{K_REPLY, {8'd0, d[7:0]}, 17'd0, r1 == 16'd0};
                bat.count = 4'd1;
                if (ee_reg || odd_reg) addr_next = adv;
                if (!ee_reg) odd_next = !odd_reg;
                if (r1 != 16'd0) begin
                    if (ee_reg)
                        bat.res[1] = '{K_EE_RD, 16'd0, a17(adv) >> 1, 1'b0};
                    else if (odd_reg)
                        bat.res[1] = '{K_FLASH_RD, 16'd0, a17(adv), 1'b0};
                    else
                        bat.res[1] = '{K_FLASH_RD, 16'd0, a17(addr_reg) | 17'd1, 1'b0};
                    bat.count = 4'd2;
                end else begin
                    phase_next = PH_IDLE;
                end
            end else if (phase_reg == PH_WAIT) begin
                phase_next = PH_IDLE;
                if (cmd_reg == "R") begin
                    bat.res[0] = '{K_REPLY, {8'd0, d[15:8]}, 17'd0, 1'b0};
                    bat.res[1] = '{K_REPLY, {8'd0, d[7:0]}, 17'd0, 1'b1};
                    bat.count = 4'd2;
                end else begin
                    bat.res[0] = '{K_REPLY, {8'd0, d[7:0]}, 17'd0, 1'b1};
                    bat.count = 4'd1;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    cmd_next = b;
                    bat.count = 4'd1;
                    bat.res[0] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                    priority case (b)
                        "L", "P": ;
                        "E": begin
                            bat.res[0].command_done = 1'b0;
                            bat.res[1] = '{K_EXIT, 16'd0, 17'd0, 1'b1};
                            bat.count = 4'd2;
                        end
                        "T", "A", "l", "C", "c", "D", "B", "g": begin
                            phase_next = PH_ARG1;
                            bat.count = 4'd0;
                        end
                        "t": begin
                            bat.res[0] = '{K_REPLY, {8'd0, CH_T44}, 17'd0, 1'b0};
                            bat.res[1] = '{K_REPLY, 16'd0, 17'd0, 1'b1};
                            bat.count = 4'd2;
                        end
                        "a": bat.res[0].reply_or_data = {8'd0, CH_Y};
                        "p": bat.res[0].reply_or_data = {8'd0, CH_S};
                        "S": begin
                            for (int i = 0; i < 7; i++)
                                bat.res[i] = '{K_REPLY, {8'd0, ident[8*i +: 8]},
                                               17'd0, i == 6};
                            bat.count = 4'd7;
                        end
                        "V": begin
                            bat.res[0] = '{K_REPLY, {8'd0, 8'h30 + {4'd0, vmajor}},
                                           17'd0, 1'b0};
                            bat.res[1] = '{K_REPLY, {8'd0, 8'h30 + {4'd0, vminor}},
                                           17'd0, 1'b1};
                            bat.count = 4'd2;
                        end
                        "s": begin
                            bat.res[0] = '{K_REPLY, {8'd0, signature[23:16]}, 17'd0, 1'b0};
                            bat.res[1] = '{K_REPLY, {8'd0, signature[15:8]}, 17'd0, 1'b0};
                            bat.res[2] = '{K_REPLY, {8'd0, signature[7:0]}, 17'd0, 1'b1};
                            bat.count = 4'd3;
                        end
                        "b": begin
                            bat.res[0] = '{K_REPLY, {8'd0, CH_Y}, 17'd0, 1'b0};
                            bat.res[1] = '{K_REPLY, {8'd0, page_bytes[15:8]}, 17'd0, 1'b0};
                            bat.res[2] = '{K_REPLY, {8'd0, page_bytes[7:0]}, 17'd0, 1'b1};
                            bat.count = 4'd3;
                        end
                        "e": begin
                            bat.res[0] = '{K_ERASE_APP, 16'd0, 17'd0, 1'b0};
                            bat.res[1] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                            bat.count = 4'd2;
                        end
                        "r", "F", "N", "Q": begin
                            bat.res[0] = '{K_FUSE_RD, 16'd0, 17'd0, 1'b0};
                            if (b == "F") bat.res[0].reply_or_data = 16'd1;
                            if (b == "N") bat.res[0].reply_or_data = 16'd2;
                            if (b == "Q") bat.res[0].reply_or_data = 16'd3;
                            phase_next = PH_WAIT;
                        end
                        "m": begin
                            bat.res[0] = '{K_PAGE_WR, 16'd0, a17(addr_reg), 1'b0};
                            bat.res[1] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                            bat.count = 4'd2;
                        end
                        "R": begin
                            bat.res[0] = '{K_WORD_RD, 16'd0, a17(addr_reg), 1'b0};
                            phase_next = PH_WAIT;
                        end
                        "d": begin
                            bat.res[0] = '{K_EE_RD, 16'd0, a17(addr_reg) >> 1, 1'b0};
                            addr_next = adv;
                            phase_next = PH_WAIT;
                        end
                        CH_ESC: bat.count = 4'd0;
                        default: bat.res[0].reply_or_data = {8'd0, CH_Q};
                    endcase
                end
                PH_ARG1: begin
                    phase_next = PH_IDLE;
                    bat.res[1] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                    bat.count = 4'd2;
                    priority case (cmd_reg)
                        "T": begin
                            bat.res[0] = bat.res[1];
                            bat.count = 4'd1;
                        end
                        "A": begin
                            held_next = b;
                            phase_next = PH_ARG2;
                            bat.count = 4'd0;
                        end
                        "l": bat.res[0] = '{K_LOCK_WR, {8'd0, b}, 17'd0, 1'b0};
                        "C": bat.res[0] = '{K_FILL, {8'd0, b}, a17(addr_reg), 1'b0};
                        "c": begin
                            bat.res[0] = '{K_FILL, {8'd0, b}, a17(addr_reg) | 17'd1, 1'b0};
                            addr_next = adv;
                        end
                        "D": begin
                            bat.res[0] = '{K_EE_WR, {8'd0, b}, a17(addr_reg) >> 1, 1'b0};
                            addr_next = adv;
                        end
                        default: begin
                            rem_next = {b, 8'd0};
                            phase_next = PH_SIZE_LO;
                            bat.count = 4'd0;
                        end
                    endcase
                end
                PH_ARG2: begin
                    addr_next = sa;
                    phase_next = PH_IDLE;
                    bat.res[0] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                    bat.count = 4'd1;
                end
                PH_SIZE_LO: begin
                    rem_next = rem_reg | {8'd0, b};
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    phase_next = PH_IDLE;
                    if (b != "E" && b != "F") begin
                        bat.res[0] = '{K_REPLY, {8'd0, CH_Q}, 17'd0, 1'b1};
                        bat.count = 4'd1;
                    end else begin
                        ee_next = (b == "E");
                        odd_next = 1'b0;
                        held_next = 8'd0;
                        if (cmd_reg == "g") begin
                            if (rem_reg != 16'd0) begin
                                if (b == "E")
                                    bat.res[0] = '{K_EE_RD, 16'd0, a17(addr_reg) >> 1, 1'b0};
                                else
                                    bat.res[0] = '{K_FLASH_RD, 16'd0, a17(addr_reg), 1'b0};
                                bat.count = 4'd1;
                                phase_next = PH_BLK_WAIT;
                            end
                        end else begin
                            page_next = addr_reg;
                            if (b == "E") begin
                                if (rem_reg == 16'd0) begin
                                    bat.res[0] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                                    bat.count = 4'd1;
                                end else begin
                                    phase_next = PH_WRITE;
                                end
                            end else begin
                                bat.res[0] = '{K_ERASE, 16'd0, a17(addr_reg), 1'b0};
                                bat.count = 4'd1;
                                if (rem_reg == 16'd0) begin
                                    bat.res[1] = '{K_PAGE_WR, 16'd0, a17(addr_reg), 1'b0};
                                    bat.res[2] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                                    bat.count = 4'd3;
                                end else begin
                                    phase_next = PH_WRITE;
                                end
                            end
                        end
                    end
                end
                PH_WRITE: begin
                    if (ee_reg) begin
                        bat.res[0] = '{K_EE_WR, {8'd0, b}, a17(addr_reg) >> 1, 1'b0};
                        bat.count = 4'd1;
                        addr_next = adv;
                    end else if (odd_reg) begin
                        bat.res[0] = '{K_FILL, {b, held_reg}, a17(addr_reg), 1'b0};
                        bat.count = 4'd1;
                        addr_next = adv;
                        odd_next = 1'b0;
                    end else begin
                        held_next = b;
                        odd_next = 1'b1;
                    end
                    rem_next = r1;
                    if (r1 == 16'd0) begin
                        phase_next = PH_IDLE;
                        if (!ee_reg) begin
                            bat.res[bat.count[2:0]] = '{K_PAGE_WR, 16'd0, a17(page_reg), 1'b0};
                            bat.count = bat.count + 4'd1;
                        end
                        bat.res[bat.count[2:0]] = '{K_REPLY, {8'd0, CH_CR}, 17'd0, 1'b1};
                        bat.count = bat.count + 4'd1;
                    end
                end
                PH_BLK_WAIT, PH_WAIT: ;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= 8'd0;
            addr_reg  <= '0;
            rem_reg   <= 16'd0;
            ee_reg    <= 1'b0;
            odd_reg   <= 1'b0;
            held_reg  <= 8'd0;
            page_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            ee_reg    <= ee_next;
            odd_reg   <= odd_next;
            held_reg  <= held_next;
            page_reg  <= page_next;
        end
    end
endmodule

// ===== rtl/core/spce_queue.sv =====
// Two-entry queue of result batches between parser and emitter.
// Depends on spce_pkg.
module spce_queue
    import spce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        w_valid,
    output logic        w_ready,
    input  spce_batch_t w_data,
    output logic        r_valid,
    input  logic        r_ready,
    output spce_batch_t r_data
);
    spce_batch_t mem_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;
    logic        wr, rd;

    assign w_ready = (cnt_reg != 2'd2);
    assign r_valid = (cnt_reg != 2'd0);
    assign r_data  = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;
    assign cnt_next = cnt_reg + {1'b0, wr} - {1'b0, rd};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= w_data;
    end
endmodule

// ===== rtl/core/spce_emitter.sv =====
// Back part: sends the results of a batch one per cycle, while m_ready is high, through an output register.
// Depends on spce_pkg.
module spce_emitter
    import spce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  spce_batch_t q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output spce_out_t   m_data
);
    logic [2:0] idx_reg;
    logic       ov_reg;
    spce_out_t  od_reg;
    logic       load, last;

    assign load    = q_valid && (!ov_reg || m_ready);
    assign last    = ({1'b0, idx_reg} + 4'd1 == q_data.count);
    assign q_ready = load && last;
    assign m_valid = ov_reg;
    assign m_data  = od_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end else begin
            if (load) begin
                ov_reg  <= 1'b1;
                idx_reg <= last ? 3'd0 : idx_reg + 3'd1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) od_reg <= q_data.res[idx_reg];
    end
endmodule

// ===== rtl/core/serial_programmer_command_engine.sv =====
// Top level of the serial programmer command engine: registers, parser, queue, emitter.
// Depends on spce_pkg, spce_parser, spce_queue, spce_emitter.
//
//  channel | ports            | payload
//  request | s_valid/s_ready  | spce_in_t  s_data
//  result  | m_valid/m_ready  | spce_out_t m_data
//  config  | cfg_valid/ready  | cfg_index, cfg_data
//
// A request is parsed in the cycle it is accepted; its results (0 to 7) leave one
// per cycle, while m_ready is high, from the emitter's output register. A two-batch
// queue decouples parser from emitter; s_ready drops when full.
// Reset is synchronous and active low.
module serial_programmer_command_engine
    import spce_pkg::*;
#(
    parameter int ADDR_BITS = 17
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  spce_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output spce_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [55:0] ident_reg;
    logic [3:0]  vmaj_reg, vmin_reg;
    logic [23:0] sig_reg;
    logic [15:0] page_reg;
    logic        bv, br, qv, qr;
    spce_batch_t bd, qd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_reg <= 56'd0;
            vmaj_reg  <= 4'd1;
            vmin_reg  <= 4'd0;
            sig_reg   <= 24'd0;
            page_reg  <= 16'd128;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IDENT:  ident_reg <= cfg_data[55:0];
                REG_VMAJOR: vmaj_reg  <= cfg_data[3:0];
                REG_VMINOR: vmin_reg  <= cfg_data[3:0];
                REG_SIG:    sig_reg   <= cfg_data[23:0];
                REG_PAGE:   page_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    spce_parser #(.ADDR_BITS(ADDR_BITS)) u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
        .b_valid(bv), .b_ready(br), .b_data(bd),
        .ident(ident_reg), .vmajor(vmaj_reg), .vminor(vmin_reg),
        .signature(sig_reg), .page_bytes(page_reg)
    );

    spce_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .w_valid(bv), .w_ready(br), .w_data(bd),
        .r_valid(qv), .r_ready(qr), .r_data(qd)
    );

    spce_emitter u_emitter (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(qv), .q_ready(qr), .q_data(qd),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ===== dv/tb_serial_programmer_command_engine.sv =====
// Testbench for serial_programmer_command_engine: directed and random host byte streams,
// checked against an in-bench predictor of the command parser. Depends on spce_pkg.
`timescale 1ns / 100ps
module tb_serial_programmer_command_engine;
    import spce_pkg::*;

    localparam int AW = 17;
    localparam logic [AW-1:0] AMASK = '1;
    localparam int WATCH_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    spce_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    spce_out_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    serial_programmer_command_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [55:0] p_ident;
    logic [3:0]  p_vmaj, p_vmin;
    logic [23:0] p_sig;
    logic [15:0] p_page;
    spce_phase_t p_phase;
    logic [7:0]  p_cmd;
    logic [AW-1:0] p_addr, p_start;
    logic [15:0] p_remain;
    logic        p_eeprom, p_odd;
    logic [7:0]  p_held;

    spce_out_t expected_results[$];
    int  errors;
    int  idle_cycles;
    int  n_sent;
    bit  hold_off;
    bit  gaps_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void push_res(logic [3:0] k, logic [15:0] d, logic [AW-1:0] a,
                                     logic done);
        spce_out_t r;
        r.kind = k;
        r.reply_or_data = d;
        r.mem_address = a;
        r.command_done = done;
        expected_results.push_back(r);
    endfunction

    function automatic void push_reply(logic [7:0] b, logic done);
        push_res(K_REPLY, {8'd0, b}, '0, done);
    endfunction

    function automatic void advance_addr();
        p_addr = (p_addr + 2) & AMASK;
    endfunction

    function automatic void issue_block_read();
        if (p_eeprom)
            push_res(K_EE_RD, 0, p_addr >> 1, 0);
        else
            push_res(K_FLASH_RD, 0, p_addr | p_odd, 0);
        p_phase = PH_BLK_WAIT;
    endfunction

    function automatic void finish_block_write();
        if (!p_eeprom)
            push_res(K_PAGE_WR, 0, p_start, 0);
        push_reply(CH_CR, 1);
        p_phase = PH_IDLE;
    endfunction

    function automatic void predict_reset();
        p_ident = '0; p_vmaj = 4'd1; p_vmin = '0; p_sig = '0; p_page = 16'd128;
        p_phase = PH_IDLE; p_cmd = '0; p_addr = '0; p_start = '0; p_remain = '0;
        p_eeprom = 0; p_odd = 0; p_held = '0;
    endfunction

    function automatic void predict_command(logic [7:0] c);
        p_cmd = c;
        case (c)
            "L", "P": push_reply(CH_CR, 1);
            "E": begin
                push_reply(CH_CR, 0);
                push_res(K_EXIT, 0, 0, 1);
            end
            "T", "A", "l", "C", "c", "D", "B", "g": p_phase = PH_ARG1;
            "t": begin
                push_reply(CH_T44, 0);
                push_reply(8'd0, 1);
            end
            "a": push_reply(CH_Y, 1);
            "p": push_reply(CH_S, 1);
            "S": for (int i = 0; i < 7; i++) push_reply(p_ident[8*i +: 8], i == 6);
            "V": begin
                push_reply(8'h30 + p_vmaj, 0);
                push_reply(8'h30 + p_vmin, 1);
            end
            "s": begin
                push_reply(p_sig[23:16], 0);
                push_reply(p_sig[15:8], 0);
                push_reply(p_sig[7:0], 1);
            end
            "b": begin
                push_reply(CH_Y, 0);
                push_reply(p_page[15:8], 0);
                push_reply(p_page[7:0], 1);
            end
            "e": begin
                push_res(K_ERASE_APP, 0, 0, 0);
                push_reply(CH_CR, 1);
            end
            "r": begin push_res(K_FUSE_RD, 0, 0, 0); p_phase = PH_WAIT; end
            "F": begin push_res(K_FUSE_RD, 1, 0, 0); p_phase = PH_WAIT; end
            "N": begin push_res(K_FUSE_RD, 2, 0, 0); p_phase = PH_WAIT; end
            "Q": begin push_res(K_FUSE_RD, 3, 0, 0); p_phase = PH_WAIT; end
            "m": begin
                push_res(K_PAGE_WR, 0, p_addr, 0);
                push_reply(CH_CR, 1);
            end
            "R": begin push_res(K_WORD_RD, 0, p_addr, 0); p_phase = PH_WAIT; end
            "d": begin
                push_res(K_EE_RD, 0, p_addr >> 1, 0);
                advance_addr();
                p_phase = PH_WAIT;
            end
            CH_ESC: ;
            default: push_reply(CH_Q, 1);
        endcase
    endfunction

    function automatic void predict_argument(logic [7:0] b);
        p_phase = PH_IDLE;
        case (p_cmd)
            "T": push_reply(CH_CR, 1);
            "A": begin p_held = b; p_phase = PH_ARG2; end
            "l": begin push_res(K_LOCK_WR, b, 0, 0); push_reply(CH_CR, 1); end
            "C": begin push_res(K_FILL, b, p_addr, 0); push_reply(CH_CR, 1); end
            "c": begin
                push_res(K_FILL, b, p_addr | 1'b1, 0);
                advance_addr();
                push_reply(CH_CR, 1);
            end
            "D": begin
                push_res(K_EE_WR, b, p_addr >> 1, 0);
                advance_addr();
                push_reply(CH_CR, 1);
            end
            default: begin p_remain = {b, 8'd0}; p_phase = PH_SIZE_LO; end
        endcase
    endfunction

    function automatic void predict_block_type(logic [7:0] b);
        p_phase = PH_IDLE;
        if (b != "E" && b != "F") begin
            push_reply(CH_Q, 1);
            return;
        end
        p_eeprom = (b == "E");
        p_odd = 0;
        p_held = '0;
        if (p_cmd == "g") begin
            if (p_remain != 0) issue_block_read();
            return;
        end
        p_start = p_addr;
        if (!p_eeprom) push_res(K_ERASE, 0, p_start, 0);
        if (p_remain == 0) finish_block_write();
        else p_phase = PH_WRITE;
    endfunction

    function automatic void predict_write_byte(logic [7:0] b);
        if (p_eeprom) begin
            push_res(K_EE_WR, b, p_addr >> 1, 0);
            advance_addr();
        end else if (p_odd) begin
            push_res(K_FILL, {b, p_held}, p_addr, 0);
            advance_addr();
            p_odd = 0;
        end else begin
            p_held = b;
            p_odd = 1;
        end
        p_remain = p_remain - 1;
        if (p_remain == 0) finish_block_write();
    endfunction

    function automatic void predict_read_return(logic [15:0] d);
        if (p_phase == PH_BLK_WAIT) begin
            p_remain = p_remain - 1;
            push_reply(d[7:0], p_remain == 0);
            if (p_eeprom) advance_addr();
            else begin
                if (p_odd) advance_addr();
                p_odd = !p_odd;
            end
            if (p_remain != 0) issue_block_read();
            else p_phase = PH_IDLE;
            return;
        end
        p_phase = PH_IDLE;
        if (p_cmd == "R") begin
            push_reply(d[15:8], 0);
            push_reply(d[7:0], 1);
        end else begin
            push_reply(d[7:0], 1);
        end
    endfunction

    function automatic void predict_request(spce_in_t r);
        if (r.opcode) begin
            if (p_phase == PH_WAIT || p_phase == PH_BLK_WAIT) predict_read_return(r.read_data);
            return;
        end
        case (p_phase)
            PH_IDLE: predict_command(r.host_byte);
            PH_ARG1: predict_argument(r.host_byte);
            PH_ARG2: begin
                p_addr = ({9'd0, p_held} << 9 | {9'd0, r.host_byte} << 1) & AMASK;
                p_phase = PH_IDLE;
                push_reply(CH_CR, 1);
            end
            PH_SIZE_LO: begin
                p_remain = p_remain | r.host_byte;
                p_phase = PH_TYPE;
            end
            PH_TYPE: predict_block_type(r.host_byte);
            PH_WRITE: predict_write_byte(r.host_byte);
            default: ;
        endcase
    endfunction

    function automatic int rand_gap();
        if (!gaps_on) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                spce_out_t e;
                e = expected_results.pop_front();
                if (m_data.kind !== e.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, m_data.kind);
                    errors++;
                end
                if (m_data.reply_or_data !== e.reply_or_data) begin
                    $display("%0t: data exp %h got %h", $time, e.reply_or_data,
                             m_data.reply_or_data);
                    errors++;
                end
                if (m_data.mem_address !== e.mem_address) begin
                    $display("%0t: addr exp %h got %h", $time, e.mem_address,
                             m_data.mem_address);
                    errors++;
                end
                if (m_data.command_done !== e.command_done) begin
                    $display("%0t: done exp %b got %b", $time, e.command_done,
                             m_data.command_done);
                    errors++;
                end
            end
        end
    end

    initial begin
        int g;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            g = rand_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("serial_programmer_command_engine test failed");
            $finish;
        end
    end

    task automatic send_request(logic op, logic [7:0] b, logic [15:0] d);
        spce_in_t r;
        int g;
        g = rand_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        r.opcode = op;
        r.host_byte = b;
        r.read_data = d;
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        predict_request(r);
        n_sent++;
    endtask

    task automatic send_bytes(string str);
        for (int i = 0; i < str.len(); i++) send_request(0, str[i], 16'($urandom));
    endtask

    task automatic read_back();
        send_request(1, 8'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IDENT:  p_ident = val[55:0];
            REG_VMAJOR: p_vmaj = val[3:0];
            REG_VMINOR: p_vmin = val[3:0];
            REG_SIG:    p_sig = val[23:0];
            REG_PAGE:   p_page = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic test_info_commands();
        send_bytes("SVsbtapLP");
        send_request(0, CH_ESC, 0);
        send_request(0, 8'hFF, 16'hFFFF);
        send_request(0, 8'h00, 0);
        send_bytes("T");
        send_request(0, 8'hFF, 0);
        send_bytes("l");
        send_request(0, 8'hA5, 0);
        send_bytes("em");
        send_bytes("E");
    endtask

    task automatic test_reads();
        send_request(1, 8'h00, 16'h1234);
        send_bytes("r"); send_request(0, "a", 0); read_back();
        send_bytes("F"); read_back();
        send_bytes("N"); read_back();
        send_bytes("Q"); send_request(1, 0, 16'hFFFF);
        send_bytes("R"); send_request(1, 0, 16'hBEEF);
        send_bytes("d"); read_back();
    endtask

    task automatic test_addressing();
        send_bytes("A"); send_request(0, 8'hFF, 0); send_request(0, 8'hFF, 0);
        send_bytes("C"); send_request(0, 8'h5A, 0);
        send_bytes("c"); send_request(0, 8'hC3, 0);
        send_bytes("D"); send_request(0, 8'h11, 0);
        send_bytes("A"); send_request(0, 8'h00, 0); send_request(0, 8'h00, 0);
    endtask

    task automatic test_blocks();
        send_bytes("B"); send_request(0, 0, 0); send_request(0, 3, 0); send_bytes("F");
        send_bytes("abc");
        send_bytes("B"); send_request(0, 0, 0); send_request(0, 0, 0); send_bytes("F");
        send_bytes("g"); send_request(0, 0, 0); send_request(0, 0, 0); send_bytes("E");
        send_bytes("B"); send_request(0, 0, 0); send_request(0, 2, 0); send_bytes("X");
        send_bytes("B"); send_request(0, 0, 0); send_request(0, 2, 0); send_bytes("E");
        send_bytes("xy");
        send_bytes("g"); send_request(0, 0, 0); send_request(0, 3, 0); send_bytes("F");
        repeat (3) read_back();
        send_bytes("g"); send_request(0, 0, 0); send_request(0, 2, 0); send_bytes("E");
        repeat (2) read_back();
    endtask

    task automatic send_random_block(int n);
        logic [7:0] t;
        t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ($urandom_range(0, 1) ? "E" : "F");
        send_request(0, $urandom_range(0, 1) ? "B" : "g", 0);
        send_request(0, n[15:8], 0);
        send_request(0, n[7:0], 0);
        send_request(0, t, 0);
        if (p_phase == PH_WRITE)
            for (int k = 0; k < 16 && p_phase == PH_WRITE; k++)
                send_request(0, 8'($urandom), 0);
        else
            for (int k = 0; k < 16 && p_phase == PH_BLK_WAIT; k++)
                read_back();
    endtask

    task automatic test_random(int count);
        int start;
        string cmds;
        cmds = "LPEtTAlCcDaSpVsbeFrNQmBgRdBgAX";
        start = n_sent;
        while (n_sent - start < count) begin
            case ($urandom_range(0, 9))
                0: send_request(1, 8'($urandom), 16'($urandom));
                1: send_request(0, 8'($urandom), 16'($urandom));
                2, 3: send_random_block($urandom_range(0, 7));
                default: begin
                    send_request(0, cmds[$urandom_range(0, cmds.len() - 1)], 0);
                    while (p_phase != PH_IDLE && n_sent - start < count + 20) begin
                        if (p_phase == PH_WAIT || p_phase == PH_BLK_WAIT) read_back();
                        else send_request(0, 8'($urandom), 0);
                    end
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 12; i++) send_bytes("S");
        drain();
    endtask

    task automatic test_config();
        write_reg(REG_IDENT, 64'h00FF_FFFF_FFFF_FFFF);
        write_reg(REG_VMAJOR, 64'd9);
        write_reg(REG_VMINOR, 64'd9);
        write_reg(REG_SIG, 64'hFFFFFF);
        write_reg(REG_PAGE, 64'hFFFF);
        send_bytes("SVsb");
        drain();
        write_reg(REG_IDENT, {8'd0, 56'($urandom) << 24 ^ 56'($urandom)});
        write_reg(REG_VMAJOR, 64'd0);
        write_reg(REG_VMINOR, 64'd0);
        write_reg(REG_SIG, 64'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_PAGE, 64'd0);
        send_bytes("SVsb");
        drain();
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        n_sent = 0;
        hold_off = 0;
        gaps_on = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        predict_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_info_commands();
        gaps_on = 1;
        test_reads();
        test_addressing();
        test_blocks();
        drain();
        test_config();
        test_backpressure();
        test_random(85);
        drain();
        write_reg(REG_IDENT, 64'h0041_4243_4445_4647);
        write_reg(REG_VMAJOR, 64'd3);
        write_reg(REG_VMINOR, 64'd7);
        write_reg(REG_SIG, 64'h1E9702);
        write_reg(REG_PAGE, 64'd256);
        test_random(85);
        drain();
        if (errors == 0 && expected_results.size() == 0)
            $display("serial_programmer_command_engine test passed");
        else
            $display("serial_programmer_command_engine test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/spce_pkg.sv
rtl/core/spce_parser.sv
rtl/core/spce_queue.sv
rtl/core/spce_emitter.sv
rtl/core/serial_programmer_command_engine.sv
dv/tb_serial_programmer_command_engine.sv
